// ===== hdl/a85_pkg.sv =====
package a85_pkg;

	// Reciprocal of 85 scaled by 2^38. Exact quotient for any 32-bit dividend.
	localparam logic [31:0] DIV_MAGIC = 32'd3233857729;
	localparam int DIV_SHIFT = 38;
	localparam int QUO_W = 64 - DIV_SHIFT;

	localparam logic [6:0] CH_OFFSET = 7'd33;
	localparam logic [6:0] CH_DIGIT_MAX = 7'd117;
	localparam logic [6:0] CH_ZERO = 7'd122;
	localparam logic [6:0] CH_END_A = 7'd126;
	localparam logic [6:0] CH_END_B = 7'd62;
	localparam logic [6:0] BASE85 = 7'd85;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One group handed from the front to the conversion side.
	typedef struct packed {
		logic [31:0] word;
		logic        zero;
		logic [2:0]  ndig;
		logic        fin;
	} job_t;

	// Converted group, digits most significant first at index 0.
	typedef struct packed {
		logic [4:0][6:0] dig;
		logic            zero;
		logic [2:0]      ndig;
		logic            fin;
	} conv_res_t;

	typedef enum logic [1:0] {
		CV_IDLE,
		CV_MUL,
		CV_FIX
	} conv_state_t;

endpackage

// ===== hdl/a85_front.sv =====
module a85_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_stall,
	input  logic [7:0]      data_byte,
	input  logic            final_byte,
	input  logic            q_full,
	output logic            push,
	output a85_pkg::job_t   push_job
);
	import a85_pkg::*;

	logic [23:0] pend_q;
	logic [1:0]  cnt_q;
	logic [31:0] acc;
	logic        accept;
	logic        complete;

	assign byte_stall = q_full;
	assign accept = byte_valid && !byte_stall;
	assign acc = {pend_q, data_byte};
	assign complete = (cnt_q == 2'd3);
	assign push = accept && (complete || final_byte);

	always_comb begin
		push_job.zero = complete && (acc == 32'd0);
		push_job.fin = final_byte;
		push_job.ndig = complete ? 3'd5 : ({1'b0, cnt_q} + 3'd2);
		unique case (cnt_q)
			2'd0: push_job.word = {acc[7:0], 24'd0};
			2'd1: push_job.word = {acc[15:0], 16'd0};
			2'd2: push_job.word = {acc[23:0], 8'd0};
			2'd3: push_job.word = acc;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (push) begin
				pend_q <= '0;
				cnt_q <= '0;
			end else begin
				pend_q <= acc[23:0];
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

endmodule

// ===== hdl/a85_queue.sv =====
module a85_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  a85_pkg::job_t   push_job,
	output logic            full,
	input  logic            pop,
	output a85_pkg::job_t   head,
	output logic            empty
);
	import a85_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// The depth is a power of two, so the pointers wrap on their own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/a85_conv.sv =====
module a85_conv (
	input  logic                 clk,
	input  logic                 arst_n,
	input  a85_pkg::job_t        head,
	input  logic                 q_empty,
	output logic                 pop,
	output a85_pkg::conv_res_t   res,
	output logic                 res_valid,
	input  logic                 take
);
	import a85_pkg::*;

	conv_state_t       st_q;
	conv_state_t       st_d;
	logic [1:0]        step_q;
	logic [31:0]       val_q;
	logic [QUO_W-1:0]  prod_q;
	logic [4:0][6:0]   dig_q;
	logic              zero_q;
	logic [2:0]        ndig_q;
	logic              fin_q;
	logic              rdy_q;

	logic              start;
	logic              finish;
	logic [31:0]       mul_a;
	logic [63:0]       prod_d;
	logic [31:0]       quo;
	logic [31:0]       quo85;
	logic [31:0]       rem_full;
	logic [6:0]        rem;

	assign start = (st_q == CV_IDLE) && !q_empty && (!rdy_q || take);
	assign pop = start;
	assign finish = (st_q == CV_FIX) && (step_q == 2'd3);

	assign mul_a = (st_q == CV_IDLE) ? head.word : val_q;
	assign prod_d = {32'd0, mul_a} * {32'd0, DIV_MAGIC};

	// Remainder from the registered quotient: q*85 as q*64 + q*16 + q*4 + q.
	assign quo = {{(32 - QUO_W){1'b0}}, prod_q};
	assign quo85 = (quo << 6) + (quo << 4) + (quo << 2) + quo;
	assign rem_full = val_q - quo85;
	assign rem = rem_full[6:0];

	assign res_valid = rdy_q;
	assign res.dig = dig_q;
	assign res.zero = zero_q;
	assign res.ndig = ndig_q;
	assign res.fin = fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CV_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			CV_IDLE: begin
				if (start && !head.zero) begin
					st_d = CV_FIX;
				end
			end
			CV_MUL: st_d = CV_FIX;
			CV_FIX: st_d = finish ? CV_IDLE : CV_MUL;
			default: st_d = CV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (finish || (start && head.zero)) begin
				rdy_q <= 1'b1;
			end else if (take) begin
				rdy_q <= 1'b0;
			end
			if (start) begin
				step_q <= '0;
			end else if (st_q == CV_MUL) begin
				step_q <= step_q + 2'd1;
			end
		end
	end

	// Each division step peels off the least significant remaining digit.
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= head.zero;
			ndig_q <= head.ndig;
			fin_q <= head.fin;
			val_q <= head.word;
		end
		if (start || (st_q == CV_MUL)) begin
			prod_q <= prod_d[63:DIV_SHIFT];
		end
		if (st_q == CV_FIX) begin
			val_q <= quo;
			dig_q[3'd4 - {1'b0, step_q}] <= rem + CH_OFFSET;
			if (finish) begin
				dig_q[0] <= quo[6:0] + CH_OFFSET;
			end
		end
	end

`ifndef SYNTHESIS
	a_rdy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rdy_q |-> st_q == CV_IDLE)
		else $error("converted result held while the divider is busy");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == CV_FIX |-> rem_full < {25'd0, BASE85})
		else $error("division by 85 left a remainder out of range");

	a_pop_free: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !rdy_q || take)
		else $error("new group taken while the previous result is unclaimed");
`endif

endmodule

// ===== hdl/a85_emit.sv =====
module a85_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  a85_pkg::conv_res_t   res,
	input  logic                 res_valid,
	output logic                 take,
	output logic                 char_valid,
	input  logic                 char_stall,
	output logic [6:0]           out_char,
	output logic                 run_last
);
	import a85_pkg::*;

	conv_res_t  buf_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic       ov_q;
	logic [6:0] char_q;
	logic       last_q;

	logic       adv;
	logic       last;
	logic [2:0] nbody;
	logic [2:0] ntot;
	logic [6:0] digit;
	logic [6:0] ch;

	assign adv = busy_q && (!ov_q || !char_stall);
	assign take = res_valid && (!busy_q || (adv && last));

	assign char_valid = ov_q;
	assign out_char = char_q;
	assign run_last = last_q;

	always_comb begin
		nbody = buf_q.zero ? 3'd1 : buf_q.ndig;
		ntot = nbody + (buf_q.fin ? 3'd2 : 3'd0);
		last = (idx_q == ntot - 3'd1);
		unique case (idx_q)
			3'd0: digit = buf_q.dig[0];
			3'd1: digit = buf_q.dig[1];
			3'd2: digit = buf_q.dig[2];
			3'd3: digit = buf_q.dig[3];
			3'd4: digit = buf_q.dig[4];
			default: digit = buf_q.dig[0];
		endcase
		priority if (idx_q < nbody) begin
			ch = buf_q.zero ? CH_ZERO : digit;
		end else if (idx_q == nbody) begin
			ch = CH_END_A;
		end else begin
			ch = CH_END_B;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (!ov_q || !char_stall) begin
				ov_q <= busy_q;
			end
			if (take) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (adv && last) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			buf_q <= res;
		end
		if (adv) begin
			char_q <= ch;
			last_q <= last;
		end
	end

`ifndef SYNTHESIS
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> (char_q >= CH_OFFSET && char_q <= CH_DIGIT_MAX) || char_q == CH_ZERO ||
			char_q == CH_END_A || char_q == CH_END_B)
		else $error("character outside the encoded alphabet");

	a_tilde_mid: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && char_q == CH_END_A |-> !last_q)
		else $error("terminator cut short after the first mark");

	a_body_len: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !buf_q.zero |-> buf_q.ndig >= 3'd2 && buf_q.ndig <= 3'd5)
		else $error("group digit count out of range");
`endif

endmodule

// ===== hdl/ascii85_stream_encoder_core.sv =====
// A zero group skips the divider and is passed on as a single 'z'.
// The shared divide-by-85 unit sets the group rate: for each of the four
// divisions per group it does a multiply and a correction step, and it takes
// no new group until it is done.
// Bytes that do not close a group are taken every cycle while the job queue has room.
// Reset (arst_n low) clears the pending group, the job queue and the output register.
module ascii85_stream_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       char_valid,
	input  logic       char_stall,
	output logic [6:0] out_char,
	output logic       run_last
);
	import a85_pkg::*;

	job_t      push_job;
	job_t      head;
	conv_res_t res;
	logic      push;
	logic      q_full;
	logic      q_empty;
	logic      pop;
	logic      res_valid;
	logic      take;

	a85_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	a85_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	a85_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.res       (res),
		.res_valid (res_valid),
		.take      (take)
	);

	a85_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.res        (res),
		.res_valid  (res_valid),
		.take       (take),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.out_char   (out_char),
		.run_last   (run_last)
	);

endmodule
